FILE: src/src_cache_pkg.sv
`default_nettype none
package src_cache_pkg;
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;
  localparam logic [2:0] CMD_FLUSH  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NOP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam int unsigned MS_PER_SEC = 1000;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] dest_addr;
    logic [21:0] lifetime_ms;
    logic [3:0]  route_len;
    logic [63:0] hops_0_1;
    logic [63:0] hops_2_3;
    logic [63:0] hops_4_5;
    logic [63:0] hops_6_7;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_len;
    logic [63:0] found_0_1;
    logic [63:0] found_2_3;
    logic [63:0] found_4_5;
    logic [63:0] found_6_7;
    logic [6:0]  occupancy;
  } rsp_word_t;
endpackage
`default_nettype wire

FILE: src/src_cache_front.sv
`default_nettype none
// Input skid into a two-entry command queue; clamps route_len and zeroes unused hops.
module src_cache_front #(
  parameter int MAX_HOPS = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  src_cache_pkg::cmd_word_t in_word,
  output logic                     q_valid,
  input  wire                      q_ready,
  output src_cache_pkg::cmd_word_t q_word
);
  src_cache_pkg::cmd_word_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  src_cache_pkg::cmd_word_t clean;
  logic [3:0] len;
  logic [255:0] hops, mask;
  logic push, pop;

  always_comb begin
    len = (in_word.route_len > 4'(MAX_HOPS)) ? 4'(MAX_HOPS) : in_word.route_len;
    hops = {in_word.hops_6_7, in_word.hops_4_5, in_word.hops_2_3, in_word.hops_0_1};
    for (int h = 0; h < 8; h++) mask[h*32 +: 32] = (4'(h) < len) ? '1 : '0;
    hops = hops & mask;
    clean = in_word;
    clean.route_len = len;
    {clean.hops_6_7, clean.hops_4_5, clean.hops_2_3, clean.hops_0_1} = hops;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
    if (push) mem_r[wp_r] <= clean;
  end
endmodule
`default_nettype wire

FILE: src/src_cache_back.sv
`default_nettype none
// Sequencer: scans every slot once per command, one slot a cycle.
module src_cache_back #(
  parameter int CAPACITY = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire [9:0]                tick_rate_hz,
  input  wire                      q_valid,
  output logic                     q_ready,
  input  src_cache_pkg::cmd_word_t q_word,
  output logic                     rsp_valid,
  input  wire                      rsp_ready,
  output src_cache_pkg::rsp_word_t rsp_word
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [54:0] RECIP_1000 = 55'd4294967;   // floor(2^32 / 1000)
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_DIV = 3'd2,
                         S_SCAN = 3'd3, S_ACT = 3'd4, S_RD = 3'd5, S_OUT = 3'd6;

  // Entry memories; valid bits are flops.
  logic [31:0]  dest_m   [CAPACITY];
  logic [31:0]  exp_m    [CAPACITY];
  logic [3:0]   len_m    [CAPACITY];
  logic [255:0] hops_m   [CAPACITY];
  logic [CAPACITY-1:0] vld_r;

  logic [2:0]  st_r;
  src_cache_pkg::cmd_word_t c_r;
  logic [CW-1:0] idx_r;           // scan counter, may reach CAPACITY
  logic [AW-1:0] rd_lat_r;        // slot held in the rd registers
  logic         rd_ok_r;
  logic [31:0]  rd_dest_r, rd_exp_r;
  logic [3:0]   rd_len_r;
  logic [255:0] rd_hops_r;
  logic         hit_r, free_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;
  logic [CW-1:0] count_r;
  logic [31:0]  time_r;
  logic [31:0]  prod_r;           // lifetime * rate, 32 bits suffice
  logic [22:0]  quo_r;            // prod_r / 1000, at most one low
  logic [22:0]  quo_nxt;
  logic [31:0]  expiry_r;
  logic [31:0]  delta, rem;
  logic [32:0]  sum;
  logic [AW-1:0] ra;
  logic [1:0]   act_st;
  logic [CW-1:0] act_cnt;
  src_cache_pkg::rsp_word_t act_rsp, rd_rsp;

  assign q_ready = (st_r == S_IDLE);
  assign rsp_valid = (st_r == S_OUT);
  assign ra = idx_r[AW-1:0];

  // divide by 1000: reciprocal estimate, then one correction step
  always_comb begin
    quo_nxt = 23'(({23'd0, prod_r} * RECIP_1000) >> 32);
    delta = {9'd0, quo_r};
    rem = prod_r - delta * 32'd1000;
    if (rem >= 32'd1000) delta = delta + 32'd1;
    sum = {1'b0, time_r} + {1'b0, delta};
  end

  // result status and count after the command
  always_comb begin
    act_st  = src_cache_pkg::ST_OK;
    act_cnt = count_r;
    case (c_r.command)
      src_cache_pkg::CMD_TICK: begin
      end
      src_cache_pkg::CMD_ADD: begin
        if (hit_r) act_st = src_cache_pkg::ST_NOP;
        else if (!free_r) act_st = src_cache_pkg::ST_FULL;
        else act_cnt = count_r + 1'b1;
      end
      src_cache_pkg::CMD_UPDATE: if (!hit_r) act_st = src_cache_pkg::ST_NOP;
      src_cache_pkg::CMD_FIND: if (!hit_r) act_st = src_cache_pkg::ST_NOP;
      src_cache_pkg::CMD_DELETE: begin
        if (!hit_r) act_st = src_cache_pkg::ST_NOP;
        else act_cnt = count_r - 1'b1;
      end
      src_cache_pkg::CMD_FLUSH: act_cnt = '0;
      default: act_st = src_cache_pkg::ST_NOP;
    endcase
    act_rsp = '0;
    act_rsp.status = act_st;
    act_rsp.occupancy = 7'(act_cnt);
    rd_rsp = '0;
    rd_rsp.status = src_cache_pkg::ST_OK;
    rd_rsp.found_len = rd_len_r;
    {rd_rsp.found_6_7, rd_rsp.found_4_5, rd_rsp.found_2_3, rd_rsp.found_0_1} = rd_hops_r;
    rd_rsp.occupancy = 7'(count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vld_r <= '0;
      count_r <= '0;
      time_r <= '0;
      rsp_word <= '0;
      idx_r <= '0;
      rd_lat_r <= '0;
      rd_ok_r <= 1'b0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            c_r <= q_word;
            hit_r <= 1'b0;
            free_r <= 1'b0;
            idx_r <= '0;
            rd_ok_r <= 1'b0;
            prod_r <= 32'({10'd0, q_word.lifetime_ms} * {22'd0, tick_rate_hz});
            if (q_word.command == src_cache_pkg::CMD_TICK && time_r != src_cache_pkg::TIME_MAX)
              time_r <= time_r + 32'd1;
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          quo_r <= quo_nxt;
          st_r <= S_DIV;
        end
        S_DIV: begin
          expiry_r <= sum[32] ? src_cache_pkg::TIME_MAX : sum[31:0];
          st_r <= S_SCAN;
        end
        S_SCAN: begin
          // pipelined read: issue idx_r, evaluate previous read
          if (idx_r < CW'(CAPACITY)) begin
            rd_dest_r <= dest_m[ra];
            rd_exp_r  <= exp_m[ra];
            rd_lat_r  <= ra;
            rd_ok_r   <= vld_r[ra];
            idx_r     <= idx_r + 1'b1;
          end else begin
            rd_ok_r <= 1'b0;
            st_r <= S_ACT;
          end
          if (rd_ok_r || (idx_r != '0 && !vld_r[rd_lat_r] && !free_r)) begin
            if (c_r.command == src_cache_pkg::CMD_TICK) begin
              if (rd_ok_r && rd_exp_r <= time_r) begin
                vld_r[rd_lat_r] <= 1'b0;
                count_r <= count_r - 1'b1;
              end
            end else if (rd_ok_r && rd_dest_r == c_r.dest_addr && !hit_r) begin
              hit_r <= 1'b1;
              hit_idx_r <= rd_lat_r;
            end
            if (!rd_ok_r && !free_r) begin
              free_r <= 1'b1;
              free_idx_r <= rd_lat_r;
            end
          end
        end
        S_ACT: begin
          rsp_word <= act_rsp;
          count_r <= act_cnt;
          st_r <= (c_r.command == src_cache_pkg::CMD_FIND && hit_r) ? S_RD : S_OUT;
          case (c_r.command)
            src_cache_pkg::CMD_ADD: if (!hit_r && free_r) vld_r[free_idx_r] <= 1'b1;
            src_cache_pkg::CMD_FIND: begin
              if (hit_r) begin
                rd_len_r  <= len_m[hit_idx_r];
                rd_hops_r <= hops_m[hit_idx_r];
              end
            end
            src_cache_pkg::CMD_DELETE: if (hit_r) vld_r[hit_idx_r] <= 1'b0;
            src_cache_pkg::CMD_FLUSH: vld_r <= '0;
            default: begin
            end
          endcase
        end
        S_RD: begin
          rsp_word <= rd_rsp;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
    // memory writes for add and update
    if (st_r == S_ACT &&
        ((c_r.command == src_cache_pkg::CMD_ADD && !hit_r && free_r) ||
         (c_r.command == src_cache_pkg::CMD_UPDATE && hit_r))) begin
      dest_m[(c_r.command == src_cache_pkg::CMD_ADD) ? free_idx_r : hit_idx_r] <= c_r.dest_addr;
      exp_m[(c_r.command == src_cache_pkg::CMD_ADD) ? free_idx_r : hit_idx_r]  <= expiry_r;
      len_m[(c_r.command == src_cache_pkg::CMD_ADD) ? free_idx_r : hit_idx_r]  <= c_r.route_len;
      hops_m[(c_r.command == src_cache_pkg::CMD_ADD) ? free_idx_r : hit_idx_r] <=
        {c_r.hops_6_7, c_r.hops_4_5, c_r.hops_2_3, c_r.hops_0_1};
    end
  end
endmodule
`default_nettype wire

FILE: src/source_route_cache_with_expiry.sv
`default_nettype none
// Channel | Dir | Handshake        | Payload
// in      | in  | in_valid/ready   | command, dest_addr, lifetime_ms, route_len, hops_*
// out     | out | out_valid/ready  | status, found_len, found_*, occupancy
// cfg     | in  | cfg_we           | cfg_tick_rate_hz (10 bits)
//
// Every command scans all CAPACITY slots, and a find hit adds a read state:
// the back end reads one slot per cycle from the entry memories.
// The front queue holds two words, so input is taken while the back end works
// or its result waits. Reset (rst_n, synchronous) clears valid bits, count,
// time and the rate register to 1000; no clearing pass is needed.
module source_route_cache_with_expiry #(
  parameter int CAPACITY = 64,
  parameter int MAX_HOPS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_command,
  input  wire  [31:0] in_dest_addr,
  input  wire  [21:0] in_lifetime_ms,
  input  wire  [3:0]  in_route_len,
  input  wire  [63:0] in_hops_0_1,
  input  wire  [63:0] in_hops_2_3,
  input  wire  [63:0] in_hops_4_5,
  input  wire  [63:0] in_hops_6_7,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_found_len,
  output logic [63:0] out_found_0_1,
  output logic [63:0] out_found_2_3,
  output logic [63:0] out_found_4_5,
  output logic [63:0] out_found_6_7,
  output logic [6:0]  out_occupancy,
  input  wire         cfg_we,
  input  wire  [9:0]  cfg_tick_rate_hz
);
  src_cache_pkg::cmd_word_t in_word, q_word;
  src_cache_pkg::rsp_word_t rsp;
  logic q_valid, q_ready;
  logic [9:0] rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rate_r <= 10'd1000;
    else if (cfg_we) rate_r <= cfg_tick_rate_hz;
  end

  assign in_word = '{in_command, in_dest_addr, in_lifetime_ms, in_route_len,
                     in_hops_0_1, in_hops_2_3, in_hops_4_5, in_hops_6_7};

  src_cache_front #(.MAX_HOPS(MAX_HOPS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .q_valid, .q_ready, .q_word
  );

  src_cache_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .tick_rate_hz(rate_r), .q_valid, .q_ready, .q_word,
    .rsp_valid(out_valid), .rsp_ready(out_ready), .rsp_word(rsp)
  );

  assign out_status    = rsp.status;
  assign out_found_len = rsp.found_len;
  assign out_found_0_1 = rsp.found_0_1;
  assign out_found_2_3 = rsp.found_2_3;
  assign out_found_4_5 = rsp.found_4_5;
  assign out_found_6_7 = rsp.found_6_7;
  assign out_occupancy = rsp.occupancy;
endmodule
`default_nettype wire

FILE: src/src_cache_checker.sv
`default_nettype none
module src_cache_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_status,
  input wire [3:0] out_found_len,
  input wire [6:0] out_occupancy
);
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found_len <= 4'd8) else $error("bad found_len");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'd0 |-> out_found_len == 4'd0) else $error("len on miss");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_occupancy)) else $error("drop");
endmodule

bind source_route_cache_with_expiry src_cache_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_status, .out_found_len, .out_occupancy
);
`default_nettype wire
